FILE: design/tqla_pkg.sv
package tqla_pkg;

  localparam int RATE_SHIFT = 16;
  localparam int RATE_HALF = 32768;
  localparam int RATE_W = 17;
  localparam logic [RATE_W-1:0] RATE_ONE = 17'h10000;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REWARD_TABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ACTION = 3'd5;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST = 17'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST = 17'd58982;
  localparam logic [RATE_W-1:0] EXPLORE_RATE_RST = 17'd655;
  localparam logic [31:0] REWARD_TABLE_RST = 32'hFDFF0103;
  localparam logic [1:0] START_STATE_RST = 2'd2;
  localparam logic START_ACTION_RST = 1'b0;

  localparam int STEP_W = 4;

  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_GQ = 2'd1;
  localparam logic [1:0] MUL_TAKEN = 2'd2;
  localparam logic [1:0] MUL_OTHER = 2'd3;

  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_TAKEN = 2'd1;
  localparam logic [1:0] WR_OTHER = 2'd2;

  localparam logic JMP_NEXT = 1'b0;
  localparam logic JMP_END_WHEN_FREE = 1'b1;

  localparam logic [STEP_W-1:0] STEP_DECIDE = 4'd8;

  typedef struct packed {
    logic rd_en;
    logic rd_cur;
    logic [1:0] mul_op;
    logic ld_gq;
    logic ld_tgt;
    logic [1:0] wr_op;
    logic upd_state;
    logic jmp;
    logic [STEP_W-1:0] jmp_step;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      4'd0: begin
        c.rd_en = 1'b1;
      end
      4'd1: begin
        c.mul_op = MUL_GQ;
        c.rd_en = 1'b1;
        c.rd_cur = 1'b1;
      end
      4'd2: begin
        c.ld_gq = 1'b1;
      end
      4'd3: begin
        c.ld_tgt = 1'b1;
      end
      4'd4: begin
        c.mul_op = MUL_TAKEN;
      end
      4'd5: begin
        c.wr_op = WR_TAKEN;
        c.mul_op = MUL_OTHER;
      end
      4'd6: begin
        c.wr_op = WR_OTHER;
        c.upd_state = 1'b1;
      end
      4'd7: begin
        c.rd_en = 1'b1;
      end
      STEP_DECIDE: begin
        c.jmp = JMP_END_WHEN_FREE;
        c.jmp_step = STEP_DECIDE;
      end
      default: begin
        c.jmp = JMP_END_WHEN_FREE;
        c.jmp_step = STEP_DECIDE;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: design/tabular_q_learning_agent.sv
// Tabular Q-learning agent, 4 states by 2 actions, epsilon-greedy choice.
// Input channel (in_valid / in_stall): outcome, rand_fraction, rand_bit.
//   A request is taken when in_valid is high and in_stall is low.
// Output channel (out_valid / out_stall): next_action, new_state, explored,
//   saturated. One result per request, held while out_stall is high.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): write only
//   while no request is in flight; cfg_ready is always high.
// Timing: in_stall stays high from the request edge until out_valid rises,
//   so no new request is taken while the 9-step control program runs one
//   shared 18-bit by (VALUE_WIDTH+1)-bit multiplier and the Q memory
//   through each update.
// If out_stall holds the previous result, the program waits on its last step
//   until the output register frees up; a new request is taken meanwhile only
//   once the program has finished.
// Reset clears the Q table, loads the register defaults, current state 2 and
//   action 0, and empties the output register.
module tabular_q_learning_agent #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] outcome,
  input  logic [15:0] rand_fraction,
  input  logic rand_bit,
  output logic out_valid,
  input  logic out_stall,
  output logic next_action,
  output logic [1:0] new_state,
  output logic explored,
  output logic saturated,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [tqla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int VW = VALUE_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int PW = VW + 19;
  localparam int RW = PW - tqla_pkg::RATE_SHIFT;
  localparam int TW = ((VW > FB + 8) ? VW : FB + 8) + 2;
  localparam logic signed [TW-1:0] QMAX_T = (TW'(1) << (VW - 1)) - TW'(1);
  localparam logic signed [TW-1:0] QMIN_T = -QMAX_T - TW'(1);

  logic [tqla_pkg::RATE_W-1:0] learn_rate;
  logic [tqla_pkg::RATE_W-1:0] discount;
  logic [tqla_pkg::RATE_W-1:0] explore_rate;
  logic [31:0] reward_table;
  logic [1:0] cur_state;
  logic cur_action;

  logic busy;
  logic [tqla_pkg::STEP_W-1:0] step;
  tqla_pkg::ctrl_t c;

  logic [1:0] outc;
  logic [15:0] frac;
  logic rbit;

  logic [VW-1:0] qmem [8];
  logic [7:0] qvalid;
  logic signed [VW-1:0] rd_a;
  logic signed [VW-1:0] rd_b;
  logic [2:0] ra_addr;
  logic [2:0] rb_addr;
  logic [2:0] wr_addr;
  logic wr_en;
  logic [VW-1:0] wr_data;

  logic signed [VW-1:0] maxq;
  logic signed [17:0] mul_rate;
  logic signed [VW:0] mul_val;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic signed [RW-1:0] rnd;
  logic signed [VW-1:0] old_sel;
  logic signed [RW-1:0] bsum;
  logic signed [VW-1:0] gq;
  logic signed [VW-1:0] target;
  logic sat;

  logic signed [7:0] reward;
  logic signed [TW-1:0] tsum;
  logic sat_hi;
  logic sat_lo;

  logic [tqla_pkg::RATE_W-1:0] cfg_rate;
  logic out_free;
  logic finish;
  logic explore;
  logic act;

  assign c = tqla_pkg::ucode(step);
  assign cfg_ready = 1'b1;
  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;
  assign finish = busy && (c.jmp == tqla_pkg::JMP_END_WHEN_FREE) && out_free;

  assign cfg_rate = (cfg_data[16:0] > tqla_pkg::RATE_ONE) ? tqla_pkg::RATE_ONE
                                                         : cfg_data[16:0];

  always_comb begin
    if (c.rd_cur) begin
      ra_addr = {cur_state, cur_action};
      rb_addr = {cur_state, ~cur_action};
    end else begin
      ra_addr = {outc, 1'b0};
      rb_addr = {outc, 1'b1};
    end
  end

  assign maxq = (rd_a > rd_b) ? rd_a : rd_b;

  always_comb begin
    case (c.mul_op)
      tqla_pkg::MUL_GQ: begin
        mul_rate = {1'b0, discount};
        mul_val = (VW + 1)'(maxq);
      end
      tqla_pkg::MUL_TAKEN: begin
        mul_rate = {1'b0, learn_rate};
        mul_val = (VW + 1)'(target) - (VW + 1)'(rd_a);
      end
      tqla_pkg::MUL_OTHER: begin
        mul_rate = {1'b0, learn_rate};
        mul_val = (VW + 1)'(gq) - (VW + 1)'(rd_b);
      end
      default: begin
        mul_rate = '0;
        mul_val = '0;
      end
    endcase
  end

  assign prod_r = prod + PW'(tqla_pkg::RATE_HALF);
  assign rnd = prod_r[PW-1:tqla_pkg::RATE_SHIFT];
  assign old_sel = (c.wr_op == tqla_pkg::WR_TAKEN) ? rd_a : rd_b;
  assign bsum = RW'(old_sel) + rnd;
  assign wr_data = bsum[VW-1:0];
  assign wr_en = busy && (c.wr_op != tqla_pkg::WR_NONE);
  assign wr_addr = (c.wr_op == tqla_pkg::WR_TAKEN) ? {cur_state, cur_action}
                                                   : {cur_state, ~cur_action};

  assign reward = reward_table[{outc, 3'b000} +: 8];
  assign tsum = (TW'(reward) <<< FB) + TW'(gq);
  assign sat_hi = tsum > QMAX_T;
  assign sat_lo = tsum < QMIN_T;

  assign explore = (rd_a == rd_b) || ({1'b0, frac} < explore_rate);
  assign act = explore ? rbit : ((rd_a > rd_b) ? 1'b0 : 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      qmem[wr_addr] <= wr_data;
    end
    if (busy && c.rd_en) begin
      rd_a <= qvalid[ra_addr] ? qmem[ra_addr] : '0;
      rd_b <= qvalid[rb_addr] ? qmem[rb_addr] : '0;
    end
    if (busy && (c.mul_op != tqla_pkg::MUL_NONE)) begin
      prod <= mul_rate * mul_val;
    end
    if (busy && c.ld_gq) begin
      gq <= rnd[VW-1:0];
    end
    if (busy && c.ld_tgt) begin
      target <= sat_hi ? QMAX_T[VW-1:0] : (sat_lo ? QMIN_T[VW-1:0] : tsum[VW-1:0]);
      sat <= sat_hi || sat_lo;
    end
    if (in_valid && !busy) begin
      outc <= outcome;
      frac <= rand_fraction;
      rbit <= rand_bit;
    end
    if (finish) begin
      next_action <= act;
      new_state <= cur_state;
      explored <= explore;
      saturated <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= tqla_pkg::LEARN_RATE_RST;
      discount <= tqla_pkg::DISCOUNT_RST;
      explore_rate <= tqla_pkg::EXPLORE_RATE_RST;
      reward_table <= tqla_pkg::REWARD_TABLE_RST;
      cur_state <= tqla_pkg::START_STATE_RST;
      cur_action <= tqla_pkg::START_ACTION_RST;
      qvalid <= '0;
      busy <= 1'b0;
      step <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tqla_pkg::CFG_LEARN_RATE: learn_rate <= cfg_rate;
          tqla_pkg::CFG_DISCOUNT: discount <= cfg_rate;
          tqla_pkg::CFG_EXPLORE_RATE: explore_rate <= cfg_rate;
          tqla_pkg::CFG_REWARD_TABLE: reward_table <= cfg_data;
          tqla_pkg::CFG_START_STATE: cur_state <= cfg_data[1:0];
          tqla_pkg::CFG_START_ACTION: cur_action <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (wr_en) begin
        qvalid[wr_addr] <= 1'b1;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        if (c.upd_state) begin
          cur_state <= outc;
        end
        case (c.jmp)
          tqla_pkg::JMP_NEXT: step <= step + 1'b1;
          tqla_pkg::JMP_END_WHEN_FREE: begin
            if (out_free) begin
              busy <= 1'b0;
              step <= '0;
              cur_action <= act;
            end else begin
              step <= c.jmp_step;
            end
          end
          default: step <= c.jmp_step;
        endcase
      end else if (in_valid) begin
        busy <= 1'b1;
        step <= '0;
      end
    end
  end

endmodule

FILE: design/tqla_chk.sv
module tqla_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic next_action,
  input logic [1:0] new_state,
  input logic explored,
  input logic saturated
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall)
    else $error("request taken without going busy");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result shown while still busy");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(next_action)
      && $stable(new_state) && $stable(explored) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind tabular_q_learning_agent tqla_chk u_tqla_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .next_action(next_action),
  .new_state(new_state),
  .explored(explored),
  .saturated(saturated)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic [tqla_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [tqla_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic ACT_COOPERATE = 1'b0;
  localparam logic ACT_DEFECT = 1'b1;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -Q_MAX - 1;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] outcome;
  logic [15:0] rand_fraction;
  logic rand_bit;
  logic out_valid;
  logic out_stall;
  logic next_action;
  logic [1:0] new_state;
  logic explored;
  logic saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [tqla_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic action;
    logic [1:0] state;
    logic explored;
    logic saturated;
  } move_t;

  move_t pending_moves[$];

  logic signed [31:0] q_mem [8];
  logic [1:0] cur_state;
  logic cur_action;
  logic [tqla_pkg::RATE_W-1:0] alpha_m;
  logic [tqla_pkg::RATE_W-1:0] gamma_m;
  logic [tqla_pkg::RATE_W-1:0] eps_m;
  logic [31:0] rewards_m;

  int err_count = 0;
  int hold_left = 0;
  int cycle_count = 0;
  bit src_idle_on = 1'b0;
  bit sink_idle_on = 1'b0;

  tabular_q_learning_agent dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic longint round_rate(input longint v);
    return (v + tqla_pkg::RATE_HALF) >>> tqla_pkg::RATE_SHIFT;
  endfunction

  function automatic longint blend_q(input longint old_q, input longint goal);
    longint a;
    a = longint'(alpha_m);
    return round_rate((longint'(tqla_pkg::RATE_ONE) - a) * old_q + a * goal);
  endfunction

  function automatic logic [tqla_pkg::RATE_W-1:0] clamp_rate(input logic [31:0] val);
    logic [tqla_pkg::RATE_W-1:0] v;
    v = val[tqla_pkg::RATE_W-1:0];
    return (v > tqla_pkg::RATE_ONE) ? tqla_pkg::RATE_ONE : v;
  endfunction

  function automatic logic [31:0] pick_rate(input bit low_bias);
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: v[tqla_pkg::RATE_W-1:0] = tqla_pkg::RATE_ONE;
      1: v[tqla_pkg::RATE_W-1:0] = '0;
      2: ;
      default: v[tqla_pkg::RATE_W-1:0] = low_bias
          ? tqla_pkg::RATE_W'($urandom_range(0, 8192))
          : tqla_pkg::RATE_W'($urandom_range(0, 65536));
    endcase
    return v;
  endfunction

  task automatic agent_step(input logic [1:0] oc, input logic [15:0] rf, input logic rb);
    move_t m;
    logic signed [7:0] rew8;
    longint rew, m0, m1, maxq, gq, goal, nv;
    logic [2:0] taken, other;
    rew8 = rewards_m[oc*8 +: 8];
    rew = rew8;
    taken = {cur_state, cur_action};
    other = {cur_state, ~cur_action};
    m0 = q_mem[{oc, 1'b0}];
    m1 = q_mem[{oc, 1'b1}];
    maxq = (m0 > m1) ? m0 : m1;
    gq = round_rate(longint'(gamma_m) * maxq);
    goal = rew * 65536 + gq;
    m.saturated = 1'b0;
    if (goal > Q_MAX) begin
      goal = Q_MAX;
      m.saturated = 1'b1;
    end
    if (goal < Q_MIN) begin
      goal = Q_MIN;
      m.saturated = 1'b1;
    end
    nv = blend_q(q_mem[taken], goal);
    q_mem[taken] = nv[31:0];
    nv = blend_q(q_mem[other], gq);
    q_mem[other] = nv[31:0];
    cur_state = oc;
    m0 = q_mem[{oc, 1'b0}];
    m1 = q_mem[{oc, 1'b1}];
    if (m0 == m1 || {1'b0, rf} < eps_m) begin
      m.action = rb;
      m.explored = 1'b1;
    end else begin
      m.action = (m0 > m1) ? ACT_COOPERATE : ACT_DEFECT;
      m.explored = 1'b0;
    end
    cur_action = m.action;
    m.state = cur_state;
    pending_moves = {pending_moves, m};
  endtask

  task automatic send_request(input logic [1:0] oc, input logic [15:0] rf, input logic rb);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    outcome <= oc;
    rand_fraction <= rf;
    rand_bit <= rb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    agent_step(oc, rf, rb);
  endtask

  task automatic send_random(input logic [1:0] oc);
    send_request(oc, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_moves.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [tqla_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tqla_pkg::CFG_LEARN_RATE: alpha_m = clamp_rate(val);
      tqla_pkg::CFG_DISCOUNT: gamma_m = clamp_rate(val);
      tqla_pkg::CFG_EXPLORE_RATE: eps_m = clamp_rate(val);
      tqla_pkg::CFG_REWARD_TABLE: rewards_m = val;
      tqla_pkg::CFG_START_STATE: cur_state = val[1:0];
      tqla_pkg::CFG_START_ACTION: cur_action = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    move_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_moves.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: act=%0d st=%0d exp=%0d sat=%0d",
                   next_action, new_state, explored, saturated);
      end else begin
        want = pending_moves.pop_front();
        if (next_action !== want.action || new_state !== want.state ||
            explored !== want.explored || saturated !== want.saturated) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: want act=%0d st=%0d exp=%0d sat=%0d, got %0d %0d %0d %0d",
                     want.action, want.state, want.explored, want.saturated,
                     next_action, new_state, explored, saturated);
        end
      end
    end
  end

  initial begin
    int burst_left;
    burst_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic test_defaults();
    send_request(2'd2, 16'hFFFF, 1'b0);
    send_request(2'd0, 16'h0000, 1'b1);
    send_request(2'd3, 16'd655, 1'b0);
    send_request(2'd1, 16'd654, 1'b1);
    send_request(2'd0, 16'hFFFF, 1'b1);
    send_request(2'd0, 16'hFFFF, 1'b0);
    send_request(2'd3, 16'hFFFF, 1'b1);
    send_request(2'd1, 16'h8000, 1'b0);
    drain();
  endtask

  task automatic test_registers();
    write_reg(tqla_pkg::CFG_LEARN_RATE, 32'd65537);
    write_reg(tqla_pkg::CFG_DISCOUNT, 32'd0);
    write_reg(tqla_pkg::CFG_EXPLORE_RATE, 32'h0001FFFF);
    write_reg(tqla_pkg::CFG_REWARD_TABLE, 32'h807F0080);
    write_reg(tqla_pkg::CFG_START_STATE, 32'd3);
    write_reg(tqla_pkg::CFG_START_ACTION, 32'd1);
    write_reg(CFG_SPARE_LO, 32'hFFFFFFFF);
    write_reg(CFG_SPARE_HI, 32'h00000000);
    end_writes();
    send_request(2'd3, 16'h0000, 1'b0);
    send_request(2'd0, 16'hFFFF, 1'b1);
    send_request(2'd1, 16'd12345, 1'b0);
    send_request(2'd2, 16'hFFFF, 1'b1);
    drain();
    write_reg(tqla_pkg::CFG_LEARN_RATE, 32'd0);
    write_reg(tqla_pkg::CFG_DISCOUNT, {15'd0, tqla_pkg::RATE_ONE});
    write_reg(tqla_pkg::CFG_EXPLORE_RATE, 32'd0);
    write_reg(tqla_pkg::CFG_START_STATE, 32'd0);
    write_reg(tqla_pkg::CFG_START_ACTION, 32'd0);
    end_writes();
    send_request(2'd0, 16'hFFFF, 1'b0);
    send_request(2'd1, 16'hFFFF, 1'b1);
    send_request(2'd0, 16'h0000, 1'b0);
    send_request(2'd3, 16'hFFFF, 1'b0);
    drain();
  endtask

  task automatic test_saturation();
    write_reg(tqla_pkg::CFG_LEARN_RATE, {15'd0, tqla_pkg::RATE_ONE});
    write_reg(tqla_pkg::CFG_DISCOUNT, {15'd0, tqla_pkg::RATE_ONE});
    write_reg(tqla_pkg::CFG_EXPLORE_RATE, 32'd0);
    write_reg(tqla_pkg::CFG_REWARD_TABLE, 32'h7F7F7F7F);
    write_reg(tqla_pkg::CFG_START_STATE, 32'd1);
    write_reg(tqla_pkg::CFG_START_ACTION, 32'd0);
    end_writes();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (300) send_random(2'd1);
    drain();
  endtask

  task automatic test_backpressure();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_left = 150;
    repeat (12) send_random(2'($urandom_range(0, 3)));
    drain();
  endtask

  task automatic test_paced();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    repeat (6) begin
      send_random(2'($urandom_range(0, 3)));
      drain();
    end
  endtask

  task automatic configure_random();
    if ($urandom_range(0, 3) != 0) write_reg(tqla_pkg::CFG_LEARN_RATE, pick_rate(1'b0));
    if ($urandom_range(0, 3) != 0) write_reg(tqla_pkg::CFG_DISCOUNT, pick_rate(1'b0));
    if ($urandom_range(0, 3) != 0) write_reg(tqla_pkg::CFG_EXPLORE_RATE, pick_rate(1'b1));
    if ($urandom_range(0, 3) != 0) write_reg(tqla_pkg::CFG_REWARD_TABLE, $urandom);
    if ($urandom_range(0, 2) == 0) write_reg(tqla_pkg::CFG_START_STATE, $urandom);
    if ($urandom_range(0, 2) == 0) write_reg(tqla_pkg::CFG_START_ACTION, $urandom);
    if ($urandom_range(0, 4) == 0) write_reg(CFG_SPARE_LO, $urandom);
    if ($urandom_range(0, 4) == 0) write_reg(CFG_SPARE_HI, $urandom);
    end_writes();
  endtask

  task automatic test_random();
    logic [1:0] oc;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    oc = 2'd0;
    for (int phase = 0; phase < 10; phase++) begin
      drain();
      configure_random();
      repeat (150) begin
        if ($urandom_range(0, 3) != 0) oc = 2'($urandom_range(0, 3));
        send_random(oc);
      end
    end
    drain();
  endtask

  task automatic test_streaming();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    configure_random();
    repeat (100) send_random(2'($urandom_range(0, 3)));
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    outcome <= '0;
    rand_fraction <= '0;
    rand_bit <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    for (int k = 0; k < 8; k++) q_mem[k] = '0;
    alpha_m = tqla_pkg::LEARN_RATE_RST;
    gamma_m = tqla_pkg::DISCOUNT_RST;
    eps_m = tqla_pkg::EXPLORE_RATE_RST;
    rewards_m = tqla_pkg::REWARD_TABLE_RST;
    cur_state = tqla_pkg::START_STATE_RST;
    cur_action = tqla_pkg::START_ACTION_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_registers();
    test_saturation();
    test_backpressure();
    test_paced();
    test_random();
    test_streaming();
    repeat (20) @(posedge clk);
    if (err_count == 0 && pending_moves.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tqla_pkg.sv
design/tabular_q_learning_agent.sv
design/tqla_chk.sv
tb/tb_top.sv
